@@ rtl/fmss_pkg.sv @@
package fmss_pkg;

  localparam int unsigned FREQ_W  = 11;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_STATIONS = 30;
  localparam int unsigned SKIP_FREQ    = 980;
  localparam int unsigned CHAN_BASE    = 870;

  localparam logic [FREQ_W-1:0] BAND_LOW_RST  = FREQ_W'(875);
  localparam logic [FREQ_W-1:0] BAND_HIGH_RST = FREQ_W'(1080);
  localparam logic [BITS_W-1:0] BAND_BITS_RST = '0;

  // request kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // seek modes
  localparam logic [MODE_W-1:0] MODE_UP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_BITS = 2'd2;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic              kind;
    logic [MODE_W-1:0] mode;
    freq_t             start_freq;
    logic              station_found;
  } item_t;

  typedef struct packed {
    freq_t             band_low;
    freq_t             band_high;
    logic [BITS_W-1:0] band_bits;
  } cfg_t;

  // only the first list slot is ever read back, so only it is kept
  typedef struct packed {
    freq_t             probe_freq;
    logic [MODE_W-1:0] seek_mode;
    logic              seek_active;
    cnt_t              station_count;
    freq_t             first_station;
  } state_t;

  typedef struct packed {
    freq_t             tune_freq;
    logic [WORD_W-1:0] tune_word;
    logic              finished;
    logic              station_stored;
    cnt_t              stored_index;
    cnt_t              found_count;
  } result_t;

  // channel number above the base, shifted up, with the fixed tune bit and band bits
  function automatic logic [WORD_W-1:0] tuning_word(freq_t f, logic [BITS_W-1:0] bits);
    freq_t chan;
    chan = f - FREQ_W'(CHAN_BASE);
    return {chan[9:0], 1'b0, 1'b1, bits};
  endfunction

endpackage

@@ rtl/fmss_in_stage.sv @@
module fmss_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  fmss_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output fmss_pkg::item_t item_o
);
  import fmss_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = valid_i && ready_o ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/fmss_step.sv @@
module fmss_step (
  input  fmss_pkg::item_t   item_i,
  input  fmss_pkg::state_t  state_i,
  input  fmss_pkg::cfg_t    cfg_i,
  output fmss_pkg::state_t  state_o,
  output fmss_pkg::result_t result_o
);
  import fmss_pkg::*;

  localparam cnt_t  MaxCnt = CNT_W'(MAX_STATIONS);
  localparam freq_t Skip   = FREQ_W'(SKIP_FREQ);

  state_t            nxt;
  freq_t             f;
  freq_t             clamp;
  logic [MODE_W-1:0] m;
  logic              fin;
  logic              stored;
  cnt_t              idx;
  logic              go;

  always_comb begin
    nxt    = state_i;
    f      = state_i.probe_freq;
    clamp  = item_i.start_freq;
    m      = item_i.mode;
    fin    = 1'b0;
    stored = 1'b0;
    idx    = '0;
    go     = 1'b1;
    if (item_i.kind == KIND_START) begin
      if (m == MODE_RSVD) begin
        m = MODE_UP;
      end
      if (clamp < cfg_i.band_low || clamp > cfg_i.band_high) begin
        clamp = cfg_i.band_low;
      end
      if (m == MODE_SCAN) begin
        f = cfg_i.band_low;
        nxt.station_count = '0;
        nxt.first_station = '0;
      end else if (m == MODE_UP) begin
        f = (clamp >= cfg_i.band_high) ? cfg_i.band_low : clamp + FREQ_W'(1);
      end else begin
        f = (clamp <= cfg_i.band_low) ? cfg_i.band_high : clamp - FREQ_W'(1);
      end
      nxt.seek_mode   = m;
      nxt.seek_active = 1'b1;
      nxt.probe_freq  = f;
    end else if (!state_i.seek_active) begin
      // report with no seek running just repeats the current frequency
      fin = 1'b1;
    end else begin
      if (item_i.station_found) begin
        if (state_i.seek_mode == MODE_SCAN) begin
          if (state_i.station_count < MaxCnt) begin
            idx = state_i.station_count;
            if (state_i.station_count == '0) begin
              nxt.first_station = f;
            end
            nxt.station_count = state_i.station_count + CNT_W'(1);
            stored = 1'b1;
          end
        end else begin
          go = 1'b0;
        end
      end
      // upper edge ends the run in every mode
      if (f >= cfg_i.band_high || nxt.station_count >= MaxCnt) begin
        go = 1'b0;
      end
      if (go) begin
        if (state_i.seek_mode == MODE_DOWN) begin
          if (f <= cfg_i.band_low) begin
            f  = cfg_i.band_low;
            go = 1'b0;
          end else begin
            f = f - FREQ_W'(1);
          end
          if (f == Skip) begin
            f = f - FREQ_W'(1);
          end
        end else begin
          if (f >= cfg_i.band_high) begin
            f  = cfg_i.band_high;
            go = 1'b0;
          end else begin
            f = f + FREQ_W'(1);
          end
          if (f == Skip) begin
            f = f + FREQ_W'(1);
          end
        end
      end
      if (!go) begin
        nxt.seek_active = 1'b0;
        if (state_i.seek_mode == MODE_SCAN) begin
          f = (nxt.station_count == '0) ? cfg_i.band_low : nxt.first_station;
        end
      end
      fin = !go;
      nxt.probe_freq = f;
    end
  end

  assign state_o                 = nxt;
  assign result_o.tune_freq      = f;
  assign result_o.tune_word      = tuning_word(f, cfg_i.band_bits);
  assign result_o.finished       = fin;
  assign result_o.station_stored = stored;
  assign result_o.stored_index   = idx;
  assign result_o.found_count    = nxt.station_count;

endmodule

@@ rtl/fm_seek_scan_controller.sv @@
// path: a request is taken into the input register; its result moves into the output register
//   once that register is free, and the outputs show it from there
// throughput: one request per cycle; the output register stalls intake only
//   while a result waits and the input register is full
// reset (async, active low): band 87.5..108.0 MHz, band bits zero, no seek running,
//   station count zero, probe frequency at the low band edge
module fm_seek_scan_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fmss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmss_pkg::FREQ_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [fmss_pkg::MODE_W-1:0]     mode_i,
  input  logic [fmss_pkg::FREQ_W-1:0]     start_freq_i,
  input  logic                            station_found_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fmss_pkg::FREQ_W-1:0]     tune_freq_o,
  output logic [fmss_pkg::WORD_W-1:0]     tune_word_o,
  output logic                            finished_o,
  output logic                            station_stored_o,
  output logic [fmss_pkg::CNT_W-1:0]      stored_index_o,
  output logic [fmss_pkg::CNT_W-1:0]      found_count_o
);
  import fmss_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  item_t   item_in, item_q;
  logic    item_valid_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_low  <= BAND_LOW_RST;
      cfg_q.band_high <= BAND_HIGH_RST;
      cfg_q.band_bits <= BAND_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAND_LOW:  cfg_q.band_low  <= cfg_wdata_i;
        CFG_BAND_HIGH: cfg_q.band_high <= cfg_wdata_i;
        CFG_BAND_BITS: cfg_q.band_bits <= cfg_wdata_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_in.kind          = kind_i;
  assign item_in.mode          = mode_i;
  assign item_in.start_freq    = start_freq_i;
  assign item_in.station_found = station_found_i;

  // result slot is free when empty or being drained this cycle
  assign advance = !out_valid_q || out_ready_i;
  assign fire    = item_valid_q && advance;

  fmss_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (item_in),
    .advance_i (advance),
    .valid_o   (item_valid_q),
    .item_o    (item_q)
  );

  fmss_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.probe_freq    <= BAND_LOW_RST;
      state_q.seek_mode     <= MODE_UP;
      state_q.seek_active   <= 1'b0;
      state_q.station_count <= '0;
      state_q.first_station <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tune_freq_o      = res_q.tune_freq;
  assign tune_word_o      = res_q.tune_word;
  assign finished_o       = res_q.finished;
  assign station_stored_o = res_q.station_stored;
  assign stored_index_o   = res_q.stored_index;
  assign found_count_o    = res_q.found_count;

  // a pending result always matches the state it left behind
  a_freq_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tune_freq_o == state_q.probe_freq)
    else $error("pending tune frequency differs from probe state");

  a_finished_vs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> finished_o == !state_q.seek_active)
    else $error("finished flag disagrees with seek state");

  a_store_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && station_stored_o |-> found_count_o == stored_index_o + CNT_W'(1))
    else $error("stored slot does not match station count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.station_count <= CNT_W'(MAX_STATIONS))
    else $error("station count beyond list size");

  a_no_index_unstored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !station_stored_o |-> stored_index_o == '0)
    else $error("slot index set without a stored station");

endmodule
